// ===== rtl/copy_insert_delta_decoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the copy/insert delta decoder
// Shared property wrappers; every property is clocked on aclk and is
// switched off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef COPY_INSERT_DELTA_DECODER_CORE_DEFINES_SVH
`define COPY_INSERT_DELTA_DECODER_CORE_DEFINES_SVH

// Same-cycle implication.
`define CIDD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CIDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cidd_pkg.sv =====
// ----------------------------------------------------------------------------
// Copy/insert delta decoder package
// Parse phases, result kinds, opcodes and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package cidd_pkg;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_OPCODE = 3'd1,
        PH_COPY   = 3'd2,
        PH_INSLEN = 3'd3,
        PH_INSDAT = 3'd4,
        PH_HALT   = 3'd5
    } phase_t;

    // Result kinds.
    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_COPY    = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // Record opcodes.
    localparam logic [7:0] OP_COPY   = 8'h00;
    localparam logic [7:0] OP_INSERT = 8'h01;

    // End status codes.
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_CORRUPT = 1'b1;

    // Header layout: four signature bytes, then two 32-bit sizes.
    localparam logic [3:0] HDR_REF_LAST_IDX = 4'd7;
    localparam logic [3:0] HDR_LAST_IDX     = 4'd11;
    localparam logic [3:0] HDR_SIG_LEN      = 4'd4;
    localparam logic [3:0] HDR_REF_END      = 4'd8;
    localparam logic [3:0] COPY_OFF_LEN     = 4'd4;
    localparam logic [3:0] COPY_LAST_IDX    = 4'd5;

    // Output word widths.
    localparam int unsigned TDATA_W = 128;
    localparam int unsigned TUSER_W = 2;

    // One result word.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  literal_value;
        logic [31:0] ref_offset;
        logic [15:0] copy_length;
        logic [31:0] dest_position;
        logic        status;
        logic [31:0] out_size;
        logic        last_result;
    } result_t;

    // Expected signature byte at header positions 0 to 3.
    function automatic logic [7:0] sig_byte(input logic [1:0] pos);
        logic [7:0] val;
        case (pos)
            2'd0: begin
                val = 8'h4F;
            end
            2'd1: begin
                val = 8'h55;
            end
            2'd2: begin
                val = 8'h43;
            end
            default: begin
                val = 8'h44;
            end
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/copy_insert_delta_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Copy/insert delta decoder core
// Parses a delta stream byte by byte into literal words, copy descriptors and
// an end-of-stream status word.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one delta byte per word in s_tdata, with s_tlast on
// the final byte of a stream. The master channel gives one result word per
// handshake: m_tuser holds the kind (literal, copy or end status), m_tdata the
// packed fields and m_tlast marks the last result caused by one input byte.
// cfg_wr_en/cfg_wr_data load the expected reference size between streams.
// A byte is registered on acceptance and parsed from that register; its
// results enter a two-word result buffer, from which the master side takes
// them. With the receiver ready, one byte is taken every cycle; a byte that
// yields two words (a literal or copy plus the end status) holds the input
// while the buffer drains.
// When m_tready is low the buffer fills, s_tready falls and nothing is lost.
// After reset the parser waits for a header, the buffer is empty and the
// reference size reads zero. Each end status returns the parser to the
// header phase for the next stream; the reference size is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module copy_insert_delta_decoder_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Reference size register.
    input  wire logic                          cfg_wr_en,
    input  wire logic [31:0]                   cfg_wr_data,
    // Delta stream in: tdata = delta_byte[7:0]; tlast = last_byte.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,
    input  wire logic                          s_tlast,
    // Results out.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // tdata = literal_value[7:0], ref_offset[39:8], copy_length[55:40],
    //         dest_position[87:56], status[88], out_size[120:89], zeros above.
    output logic [cidd_pkg::TDATA_W-1:0]       m_tdata,
    // tuser = kind[1:0].
    output logic [cidd_pkg::TUSER_W-1:0]       m_tuser,
    // tlast = last_result.
    output logic                               m_tlast
);

    // Configuration register.
    logic [31:0] ref_size_reg;

    // Input stage.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // Parser state.
    cidd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  idx_reg, idx_next;
    logic [31:0] hdr_ref_reg, hdr_ref_next;
    logic [31:0] tsz_reg, tsz_next;
    logic [31:0] out_count_reg, out_count_next;
    logic [31:0] arg_off_reg, arg_off_next;
    logic [15:0] arg_len_reg, arg_len_next;
    logic        corrupt_reg, corrupt_next;

    // Result buffer.
    cidd_pkg::result_t q0_reg, q1_reg;
    logic [1:0]  cnt_reg;

    // Step results.
    cidd_pkg::result_t data_res, end_res;
    logic        has_data;
    logic        stream_ok;
    logic [31:0] end_count;
    logic        pop;
    logic        fire;
    logic [15:0] len_full;
    logic [32:0] end_ref;
    logic [32:0] end_out;
    logic [32:0] ins_end;
    logic        copy_over;

    // Assertion helpers.
    logic        end_shown;
    logic        parse_idle;

    // Handshakes: a parsed byte may load the buffer only when it drains empty.
    assign pop      = (cnt_reg != 2'd0) && m_tready;
    assign fire     = in_valid_reg && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop));
    assign s_tready = !in_valid_reg || fire;

    // Output mapping.
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tuser  = q0_reg.kind;
    assign m_tlast  = q0_reg.last_result;
    assign m_tdata  = {7'd0, q0_reg.out_size, q0_reg.status, q0_reg.dest_position,
                       q0_reg.copy_length, q0_reg.ref_offset, q0_reg.literal_value};

    // The full 16-bit length once its high byte is on the input.
    assign len_full = {in_byte_reg, arg_len_reg[7:0]};

    // Overrun sums, kept one bit wider than the operands.
    assign end_ref   = {1'b0, arg_off_reg} + {17'd0, len_full};
    assign end_out   = {1'b0, out_count_reg} + {17'd0, len_full};
    assign ins_end   = end_out;
    assign copy_over = (end_ref > {1'b0, ref_size_reg}) || (end_out > {1'b0, tsz_reg});

    // Parser next state: one byte per step.
    always_comb begin
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        hdr_ref_next   = hdr_ref_reg;
        tsz_next       = tsz_reg;
        out_count_next = out_count_reg;
        arg_off_next   = arg_off_reg;
        arg_len_next   = arg_len_reg;
        corrupt_next   = corrupt_reg;
        case (phase_reg)
            cidd_pkg::PH_HEADER: begin
                if (idx_reg < cidd_pkg::HDR_SIG_LEN) begin
                    if (in_byte_reg != cidd_pkg::sig_byte(idx_reg[1:0])) begin
                        corrupt_next = 1'b1;
                        phase_next   = cidd_pkg::PH_HALT;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end else if (idx_reg < cidd_pkg::HDR_REF_END) begin
                    hdr_ref_next[{idx_reg[1:0], 3'b000} +: 8] = in_byte_reg;
                    if ((idx_reg == cidd_pkg::HDR_REF_LAST_IDX) &&
                        (hdr_ref_next != ref_size_reg)) begin
                        corrupt_next = 1'b1;
                        phase_next   = cidd_pkg::PH_HALT;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end else begin
                    tsz_next[{idx_reg[1:0], 3'b000} +: 8] = in_byte_reg;
                    if (idx_reg >= cidd_pkg::HDR_LAST_IDX) begin
                        phase_next = (tsz_next == 32'd0) ? cidd_pkg::PH_HALT
                                                         : cidd_pkg::PH_OPCODE;
                        idx_next   = 4'd0;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            cidd_pkg::PH_OPCODE: begin
                idx_next     = 4'd0;
                arg_off_next = 32'd0;
                arg_len_next = 16'd0;
                if (in_byte_reg == cidd_pkg::OP_COPY) begin
                    phase_next = cidd_pkg::PH_COPY;
                end else if (in_byte_reg == cidd_pkg::OP_INSERT) begin
                    phase_next = cidd_pkg::PH_INSLEN;
                end else begin
                    corrupt_next = 1'b1;
                    phase_next   = cidd_pkg::PH_HALT;
                end
            end
            cidd_pkg::PH_COPY: begin
                idx_next = idx_reg + 4'd1;
                if (idx_reg < cidd_pkg::COPY_OFF_LEN) begin
                    arg_off_next[{idx_reg[1:0], 3'b000} +: 8] = in_byte_reg;
                end else begin
                    arg_len_next[{idx_reg[0], 3'b000} +: 8] = in_byte_reg;
                    if (idx_reg >= cidd_pkg::COPY_LAST_IDX) begin
                        if (copy_over) begin
                            corrupt_next = 1'b1;
                            phase_next   = cidd_pkg::PH_HALT;
                        end else begin
                            out_count_next = end_out[31:0];
                            idx_next       = 4'd0;
                            phase_next     = (end_out[31:0] == tsz_reg) ? cidd_pkg::PH_HALT
                                                                        : cidd_pkg::PH_OPCODE;
                        end
                    end
                end
            end
            cidd_pkg::PH_INSLEN: begin
                arg_len_next[{idx_reg[0], 3'b000} +: 8] = in_byte_reg;
                idx_next = idx_reg + 4'd1;
                if (idx_reg != 4'd0) begin
                    idx_next = 4'd0;
                    if (arg_len_next == 16'd0) begin
                        phase_next = cidd_pkg::PH_OPCODE;
                    end else if (ins_end > {1'b0, tsz_reg}) begin
                        corrupt_next = 1'b1;
                        phase_next   = cidd_pkg::PH_HALT;
                    end else begin
                        phase_next = cidd_pkg::PH_INSDAT;
                    end
                end
            end
            cidd_pkg::PH_INSDAT: begin
                out_count_next = out_count_reg + 32'd1;
                arg_len_next   = arg_len_reg - 16'd1;
                if (arg_len_next == 16'd0) begin
                    phase_next = (out_count_next == tsz_reg) ? cidd_pkg::PH_HALT
                                                             : cidd_pkg::PH_OPCODE;
                end
            end
            default: begin
            end
        endcase

        // End of stream: judge the stream, then back to the header phase.
        stream_ok = !corrupt_next && ((phase_next == cidd_pkg::PH_OPCODE) ||
                                      (phase_next == cidd_pkg::PH_HALT));
        end_count = out_count_next;
        if (in_last_reg) begin
            phase_next     = cidd_pkg::PH_HEADER;
            idx_next       = 4'd0;
            hdr_ref_next   = 32'd0;
            tsz_next       = 32'd0;
            out_count_next = 32'd0;
            arg_off_next   = 32'd0;
            arg_len_next   = 16'd0;
            corrupt_next   = 1'b0;
        end
    end

    // Parser outputs: the literal or copy word and the status word.
    always_comb begin
        has_data = 1'b0;
        data_res = '0;
        case (phase_reg)
            cidd_pkg::PH_COPY: begin
                if ((idx_reg >= cidd_pkg::COPY_LAST_IDX) && !copy_over) begin
                    has_data               = 1'b1;
                    data_res.kind          = cidd_pkg::KIND_COPY;
                    data_res.ref_offset    = arg_off_reg;
                    data_res.copy_length   = len_full;
                    data_res.dest_position = out_count_reg;
                    data_res.out_size      = end_out[31:0];
                end
            end
            cidd_pkg::PH_INSDAT: begin
                has_data               = 1'b1;
                data_res.kind          = cidd_pkg::KIND_LITERAL;
                data_res.literal_value = in_byte_reg;
                data_res.dest_position = out_count_reg;
                data_res.out_size      = out_count_reg + 32'd1;
            end
            default: begin
            end
        endcase
        data_res.last_result = !in_last_reg;
        end_res              = '0;
        end_res.kind         = cidd_pkg::KIND_END;
        end_res.status       = stream_ok ? cidd_pkg::STATUS_OK : cidd_pkg::STATUS_CORRUPT;
        end_res.out_size     = end_count;
        end_res.last_result  = 1'b1;
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_size_reg <= 32'd0;
        end else if (cfg_wr_en) begin
            ref_size_reg <= cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= cidd_pkg::PH_HEADER;
            idx_reg       <= 4'd0;
            hdr_ref_reg   <= 32'd0;
            tsz_reg       <= 32'd0;
            out_count_reg <= 32'd0;
            arg_off_reg   <= 32'd0;
            arg_len_reg   <= 16'd0;
            corrupt_reg   <= 1'b0;
        end else if (fire) begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            hdr_ref_reg   <= hdr_ref_next;
            tsz_reg       <= tsz_next;
            out_count_reg <= out_count_next;
            arg_off_reg   <= arg_off_next;
            arg_len_reg   <= arg_len_next;
            corrupt_reg   <= corrupt_next;
        end
    end

    // Result buffer count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (fire) begin
            cnt_reg <= {1'b0, has_data} + {1'b0, in_last_reg};
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Result buffer words: load on a parsed byte, shift on a pop.
    always_ff @(posedge aclk) begin
        if (fire) begin
            q0_reg <= has_data ? data_res : end_res;
            q1_reg <= end_res;
        end else if (pop) begin
            q0_reg <= q1_reg;
        end
    end

    // Checks.
    assign end_shown  = m_tvalid && (m_tuser == cidd_pkg::KIND_END);
    assign parse_idle = (phase_reg == cidd_pkg::PH_HEADER) && (out_count_reg == 32'd0);

`include "copy_insert_delta_decoder_core_defines.svh"

    `CIDD_ASSERT_NOW(a_cnt_range, 1'b1, cnt_reg != 2'd3, "result buffer count out of range")
    `CIDD_ASSERT_NOW(a_fire_room, fire, (cnt_reg == 2'd0) || pop, "word parsed into a busy buffer")
    `CIDD_ASSERT_NOW(a_end_last, end_shown, m_tlast, "end status not marked last")
    `CIDD_ASSERT_NEXT(a_restart, fire && in_last_reg, parse_idle, "parser not restarted after end")
    `CIDD_ASSERT_NOW(a_count_bound, 1'b1, out_count_reg <= tsz_reg, "count beyond target size")

endmodule

`default_nettype wire
